// File: sv/bsi_pkg.sv
package bsi_pkg;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_CONN,
        ST_READ,
        ST_ITER,
        ST_A_RD,
        ST_A_ACC,
        ST_A_LNK,
        ST_A_LNK2,
        ST_A_MUL,
        ST_A_MW,
        ST_A_ADD,
        ST_A_WR,
        ST_B_RD,
        ST_B_MUL,
        ST_B_MW,
        ST_B_UPD,
        ST_C_RD,
        ST_C_CHK,
        ST_C_SRD,
        ST_C_DIV,
        ST_C_DWT,
        ST_CLR,
        ST_DONE
    } t_state;

    localparam logic [1:0] CMD_LOAD_ENTRY = 2'd0;
    localparam logic [1:0] CMD_LOAD_CONN  = 2'd1;
    localparam logic [1:0] CMD_RUN        = 2'd2;
    localparam logic [1:0] CMD_READ       = 2'd3;

    localparam logic [1:0] KIND_INTERIOR  = 2'd0;
    localparam logic [1:0] KIND_BOUNDARY  = 2'd2;

    localparam logic [1:0] CFG_OMEGA      = 2'd0;
    localparam logic [1:0] CFG_TOLERANCE  = 2'd1;
    localparam logic [1:0] CFG_MAX_ITER   = 2'd2;
    localparam logic [1:0] CFG_COUNT      = 2'd3;

    localparam int VAL_W  = 32;
    localparam int RND_W  = 36;
    localparam int ACC_W  = 44;
    localparam int SUM_W  = 40;
    localparam int NUM_W  = 60;
    localparam int FRAC_W = 28;
    localparam int WIDE_W = 48;
    localparam int LINK_W = 12;
    localparam int SUP_W  = 10;
    localparam int KIND_W = 2;

    localparam logic signed [WIDE_W-1:0] S32_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [WIDE_W-1:0] S32_MIN = -48'sh0000_8000_0000;
    localparam logic signed [WIDE_W-1:0] S40_MAX = 48'sh007F_FFFF_FFFF;
    localparam logic signed [WIDE_W-1:0] S40_MIN = -48'sh0080_0000_0000;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > S32_MAX) begin
            r = S32_MAX[VAL_W-1:0];
        end else if (v < S32_MIN) begin
            r = S32_MIN[VAL_W-1:0];
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat40(input logic signed [WIDE_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        if (v > S40_MAX) begin
            r = S40_MAX[SUM_W-1:0];
        end else if (v < S40_MIN) begin
            r = S40_MIN[SUM_W-1:0];
        end else begin
            r = v[SUM_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: sv/bsi_mul.sv
module bsi_mul
    import bsi_pkg::*;
(
    input  logic                    i_clk,
    input  logic signed [VAL_W-1:0] i_a,
    input  logic signed [VAL_W-1:0] i_b,
    output logic signed [RND_W-1:0] o_rnd
);

    localparam logic signed [2*VAL_W-1:0] HALF = 64'sd1 <<< (FRAC_W - 1);

    logic signed [2*VAL_W-1:0] r_prod;
    logic signed [2*VAL_W-1:0] sum;
    logic signed [RND_W-1:0]   r_rnd;

    // round half up, then floor shift
    assign sum = r_prod + HALF;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_rnd  <= sum[2*VAL_W-1:FRAC_W];
    end

    assign o_rnd = r_rnd;

endmodule

// File: sv/bsi_div.sv
module bsi_div
    import bsi_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [SUM_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [VAL_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);
    localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(64'h7FFF_FFFF);
    localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(64'h8000_0000);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [SUM_W-1:0] r_rem;
    logic [SUM_W-1:0] r_dm;
    logic             r_neg;
    logic [SUM_W:0]   trial;
    logic [SUM_W:0]   diff;
    logic             take;
    logic [NUM_W-1:0] num_mag;
    logic [SUM_W-1:0] den_mag;

    assign num_mag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign den_mag = i_den[SUM_W-1] ? SUM_W'(-i_den) : SUM_W'(i_den);
    assign trial   = {r_rem, r_q[NUM_W-1]};
    assign diff    = trial - {1'b0, r_dm};
    assign take    = trial >= {1'b0, r_dm};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // one quotient bit a cycle, restoring
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= num_mag;
            r_rem <= '0;
            r_dm  <= den_mag;
            r_neg <= i_num[NUM_W-1] ^ i_den[SUM_W-1];
            r_cnt <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], take};
            r_rem <= take ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_comb begin
        if (r_neg) begin
            o_quot = (r_q > NEG_LIM) ? S32_MIN[VAL_W-1:0] : VAL_W'(-r_q[VAL_W-1:0]);
        end else begin
            o_quot = (r_q > POS_LIM) ? S32_MAX[VAL_W-1:0] : r_q[VAL_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

// File: sv/basis_smoothing_iteration_unit.sv
// Jacobi smoothing of a basis held in on-chip stores, Q4.28 fixed point. Run and
// read commands each return through a single result register; loads give no result.
// A load of a connection does a read-modify-write of the slot count. A run is driven
// by one sequencer around one 32x32 multiplier and one bit-serial divider: each pass
// reads every entry and its connection slots, then applies the relaxation step to each
// entry, then checks each entry for the boundary kind and divides each boundary entry
// with a non-zero cell sum by that sum, then clears the cell sums. After reset a
// clearing pass zeroes the slot counts and cell sums before the first item is taken.
module basis_smoothing_iteration_unit
    import bsi_pkg::*;
#(
    parameter int MAX_ENTRIES    = 4096,
    parameter int MAX_FINE_CELLS = 1024,
    parameter int CONN_SLOTS     = 8,
    parameter int CHECK_INTERVAL = 25
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic [30:0]             i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_cmd,
    input  logic [11:0]             i_entry_index,
    input  logic [2:0]              i_slot,
    input  logic [11:0]             i_link,
    input  logic signed [31:0]      i_data_value,
    input  logic [1:0]              i_cell_kind,
    input  logic [9:0]              i_fine_cell,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [31:0]      o_read_value,
    output logic [15:0]             o_iterations_done,
    output logic                    o_converged
);

    localparam int EW    = $clog2(MAX_ENTRIES);
    localparam int FW    = $clog2(MAX_FINE_CELLS);
    localparam int SW    = (CONN_SLOTS > 1) ? $clog2(CONN_SLOTS) : 1;
    localparam int CW    = $clog2(CONN_SLOTS + 1);
    localparam int KW    = (CHECK_INTERVAL > 1) ? $clog2(CHECK_INTERVAL) : 1;
    localparam int MAXEF = (MAX_ENTRIES > MAX_FINE_CELLS) ? MAX_ENTRIES : MAX_FINE_CELLS;
    localparam int XW    = $clog2(MAXEF);
    localparam int LD    = MAX_ENTRIES << SW;

    localparam logic [XW-1:0] INIT_LAST = XW'(MAXEF - 1);
    localparam logic [XW-1:0] CLR_LAST  = XW'(MAX_FINE_CELLS - 1);
    localparam logic [KW-1:0] CHK_LAST  = KW'(CHECK_INTERVAL - 1);

    // stores
    logic signed [VAL_W-1:0]  r_basis_mem [MAX_ENTRIES];
    logic signed [VAL_W-1:0]  r_upd_mem   [MAX_ENTRIES];
    logic [KIND_W-1:0]        r_kind_mem  [MAX_ENTRIES];
    logic [SUP_W-1:0]         r_sup_mem   [MAX_ENTRIES];
    logic [CW-1:0]            r_lcnt_mem  [MAX_ENTRIES];
    logic [LINK_W-1:0]        r_link_mem  [LD];
    logic signed [VAL_W-1:0]  r_coef_mem  [LD];
    logic signed [SUM_W-1:0]  r_csum_mem  [MAX_FINE_CELLS];

    logic signed [VAL_W-1:0]  r_basis_rd;
    logic signed [VAL_W-1:0]  r_upd_rd;
    logic [KIND_W-1:0]        r_kind_rd;
    logic [SUP_W-1:0]         r_sup_rd;
    logic [CW-1:0]            r_lcnt_rd;
    logic [LINK_W-1:0]        r_link_rd;
    logic signed [VAL_W-1:0]  r_coef_rd;
    logic signed [SUM_W-1:0]  r_csum_rd;

    logic                     basis_we;
    logic [EW-1:0]            basis_wa;
    logic signed [VAL_W-1:0]  basis_wd;
    logic [EW-1:0]            basis_ra;
    logic                     upd_we;
    logic                     ent_we;
    logic                     lcnt_we;
    logic [EW-1:0]            lcnt_wa;
    logic [CW-1:0]            lcnt_wd;
    logic [EW-1:0]            lcnt_ra;
    logic                     conn_we;
    logic                     csum_we;
    logic [FW-1:0]            csum_wa;
    logic signed [SUM_W-1:0]  csum_wd;

    // configuration
    logic [30:0]              r_omega;
    logic [30:0]              r_tol;
    logic [15:0]              r_max;
    logic [12:0]              r_count;

    // sequencer
    t_state                   r_state, n_state;
    logic [EW:0]              r_i, n_i;
    logic [CW-1:0]            r_k, n_k;
    logic [CW-1:0]            r_cnt;
    logic [EW:0]              r_n;
    logic [15:0]              r_iter, n_iter;
    logic [KW-1:0]            r_chk, n_chk;
    logic                     r_done, n_done;
    logic                     r_check, n_check;
    logic [XW-1:0]            r_clr, n_clr;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [VAL_W-1:0]  r_coef;
    logic signed [VAL_W-1:0]  r_val;
    logic signed [VAL_W-1:0]  r_upd;
    logic [KIND_W-1:0]        r_kind;
    logic [SUP_W-1:0]         r_sup;
    logic [EW-1:0]            r_cidx;
    logic [CW-1:0]            r_cslot;
    logic                     r_rd_ok;
    logic [15:0]              r_iter_cnt;
    logic                     r_conv;

    logic                     r_out_valid;
    logic signed [VAL_W-1:0]  r_out_value;
    logic [15:0]              r_out_iter;
    logic                     r_out_conv;

    logic                     ready;
    logic                     accept;
    logic                     idx_ok;
    logic                     slot_ok;
    logic [EW-1:0]            idx;
    logic [EW+SW-1:0]         conn_wa;
    logic [EW+SW-1:0]         conn_ra;
    logic                     link_ok;
    logic                     sup_ok_rd;
    logic                     sup_ok_reg;
    logic signed [VAL_W-1:0]  mul_a;
    logic signed [VAL_W-1:0]  mul_b;
    logic signed [RND_W-1:0]  mul_rnd;
    logic                     div_start;
    logic                     div_done;
    logic signed [VAL_W-1:0]  div_quot;
    logic signed [VAL_W-1:0]  relaxed;
    logic signed [SUM_W-1:0]  csum_next;
    logic signed [VAL_W:0]    upd_ext;
    logic [VAL_W:0]           upd_mag;
    logic [EW:0]              n_clamped;

    assign idx        = EW'(i_entry_index);
    assign idx_ok     = {20'd0, i_entry_index} < MAX_ENTRIES;
    assign slot_ok    = {29'd0, i_slot} < CONN_SLOTS;
    assign conn_wa    = {idx, SW'(i_slot)};
    assign conn_ra    = {r_i[EW-1:0], r_k[SW-1:0]};
    assign link_ok    = {20'd0, r_link_rd} < MAX_ENTRIES;
    assign sup_ok_rd  = {22'd0, r_sup_rd} < MAX_FINE_CELLS;
    assign sup_ok_reg = {22'd0, r_sup} < MAX_FINE_CELLS;
    assign relaxed    = sat32(WIDE_W'(r_val) - WIDE_W'(mul_rnd));
    assign csum_next  = sat40(WIDE_W'(r_csum_rd) + WIDE_W'(relaxed));
    assign upd_ext    = (VAL_W+1)'(r_upd);
    assign upd_mag    = r_upd[VAL_W-1] ? (VAL_W+1)'(-upd_ext) : (VAL_W+1)'(upd_ext);
    assign n_clamped  = ({19'd0, r_count} > MAX_ENTRIES) ? (EW+1)'(MAX_ENTRIES)
                                                         : (EW+1)'(r_count);

    bsi_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_rnd (mul_rnd)
    );

    bsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_val, FRAC_W'(0)}),
        .i_den   (r_csum_rd),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // memories
    always_ff @(posedge i_clk) begin
        if (basis_we) begin
            r_basis_mem[basis_wa] <= basis_wd;
        end
        r_basis_rd <= r_basis_mem[basis_ra];
    end

    always_ff @(posedge i_clk) begin
        if (upd_we) begin
            r_upd_mem[r_i[EW-1:0]] <= sat32(WIDE_W'(r_acc));
        end
        r_upd_rd <= r_upd_mem[r_i[EW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_kind_mem[idx] <= i_cell_kind;
            r_sup_mem[idx]  <= i_fine_cell;
        end
        r_kind_rd <= r_kind_mem[r_i[EW-1:0]];
        r_sup_rd  <= r_sup_mem[r_i[EW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (lcnt_we) begin
            r_lcnt_mem[lcnt_wa] <= lcnt_wd;
        end
        r_lcnt_rd <= r_lcnt_mem[lcnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (conn_we) begin
            r_link_mem[conn_wa] <= i_link;
            r_coef_mem[conn_wa] <= i_data_value;
        end
        r_link_rd <= r_link_mem[conn_ra];
        r_coef_rd <= r_coef_mem[conn_ra];
    end

    always_ff @(posedge i_clk) begin
        if (csum_we) begin
            r_csum_mem[csum_wa] <= csum_wd;
        end
        r_csum_rd <= r_csum_mem[FW'(r_sup)];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_omega <= 31'd268435456;
            r_tol   <= '0;
            r_max   <= 16'd100;
            r_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OMEGA:     r_omega <= i_cfg_data;
                CFG_TOLERANCE: r_tol   <= i_cfg_data;
                CFG_MAX_ITER:  r_max   <= i_cfg_data[15:0];
                CFG_COUNT:     r_count <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_i     <= '0;
            r_k     <= '0;
            r_iter  <= '0;
            r_chk   <= '0;
            r_done  <= 1'b0;
            r_check <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_k     <= n_k;
            r_iter  <= n_iter;
            r_chk   <= n_chk;
            r_done  <= n_done;
            r_check <= n_check;
            r_clr   <= n_clr;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_k       = r_k;
        n_iter    = r_iter;
        n_chk     = r_chk;
        n_done    = r_done;
        n_check   = r_check;
        n_clr     = r_clr;
        ready     = 1'b0;
        accept    = 1'b0;
        basis_we  = 1'b0;
        basis_wa  = r_i[EW-1:0];
        basis_wd  = relaxed;
        basis_ra  = r_i[EW-1:0];
        upd_we    = 1'b0;
        ent_we    = 1'b0;
        lcnt_we   = 1'b0;
        lcnt_wa   = idx;
        lcnt_wd   = '0;
        lcnt_ra   = r_i[EW-1:0];
        conn_we   = 1'b0;
        csum_we   = 1'b0;
        csum_wa   = FW'(r_sup);
        csum_wd   = csum_next;
        mul_a     = r_coef;
        mul_b     = r_basis_rd;
        div_start = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                lcnt_we = {{(32-XW){1'b0}}, r_clr} < MAX_ENTRIES;
                lcnt_wa = EW'(r_clr);
                csum_we = {{(32-XW){1'b0}}, r_clr} < MAX_FINE_CELLS;
                csum_wa = FW'(r_clr);
                csum_wd = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == INIT_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                ready  = !r_out_valid || i_cmd == CMD_LOAD_ENTRY || i_cmd == CMD_LOAD_CONN;
                accept = i_in_valid && ready;
                if (accept) begin
                    unique case (i_cmd)
                        CMD_LOAD_ENTRY: begin
                            basis_we = idx_ok;
                            basis_wa = idx;
                            basis_wd = i_data_value;
                            ent_we   = idx_ok;
                            lcnt_we  = idx_ok;
                        end
                        CMD_LOAD_CONN: begin
                            conn_we = idx_ok && slot_ok;
                            lcnt_ra = idx;
                            if (idx_ok && slot_ok) begin
                                n_state = ST_CONN;
                            end
                        end
                        CMD_RUN: begin
                            n_iter  = '0;
                            n_chk   = '0;
                            n_done  = 1'b0;
                            n_state = (r_max == 16'd0) ? ST_DONE : ST_ITER;
                        end
                        CMD_READ: begin
                            basis_ra = idx;
                            n_state  = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CONN: begin
                lcnt_wa = r_cidx;
                lcnt_wd = r_cslot;
                lcnt_we = r_lcnt_rd < r_cslot;
                n_state = ST_IDLE;
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            ST_ITER: begin
                n_check = r_chk == '0 && r_iter != 16'd0 && r_tol != '0;
                n_done  = n_check;
                n_i     = '0;
                n_clr   = '0;
                n_state = (r_n == '0) ? ST_CLR : ST_A_RD;
            end
            // update pass
            ST_A_RD: begin
                n_state = ST_A_ACC;
            end
            ST_A_ACC: begin
                n_k     = '0;
                n_state = (r_lcnt_rd == '0) ? ST_A_WR : ST_A_LNK;
            end
            ST_A_LNK: begin
                n_state = ST_A_LNK2;
            end
            ST_A_LNK2: begin
                basis_ra = EW'(r_link_rd);
                if (link_ok) begin
                    n_state = ST_A_MUL;
                end else if (r_k + 1'b1 < r_cnt) begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_A_LNK;
                end else begin
                    n_state = ST_A_WR;
                end
            end
            ST_A_MUL: begin
                n_state = ST_A_MW;
            end
            ST_A_MW: begin
                n_state = ST_A_ADD;
            end
            ST_A_ADD: begin
                if (r_k + 1'b1 < r_cnt) begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_A_LNK;
                end else begin
                    n_state = ST_A_WR;
                end
            end
            ST_A_WR: begin
                upd_we = 1'b1;
                if (r_i + 1'b1 < r_n) begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_A_RD;
                end else begin
                    n_i     = '0;
                    n_state = ST_B_RD;
                end
            end
            // relaxation pass
            ST_B_RD: begin
                n_state = ST_B_MUL;
            end
            ST_B_MUL: begin
                mul_a   = VAL_W'({1'b0, r_omega});
                mul_b   = r_upd_rd;
                n_state = ST_B_MW;
            end
            ST_B_MW: begin
                n_state = ST_B_UPD;
            end
            ST_B_UPD: begin
                basis_we = r_kind == KIND_INTERIOR || r_kind == KIND_BOUNDARY;
                csum_we  = r_kind == KIND_BOUNDARY && sup_ok_reg;
                if (r_kind == KIND_INTERIOR && r_check && upd_mag > {2'b00, r_tol}) begin
                    n_done = 1'b0;
                end
                if (r_i + 1'b1 < r_n) begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_B_RD;
                end else begin
                    n_i     = '0;
                    n_state = ST_C_RD;
                end
            end
            // boundary normalisation pass
            ST_C_RD: begin
                n_state = ST_C_CHK;
            end
            ST_C_CHK: begin
                if (r_kind_rd == KIND_BOUNDARY && sup_ok_rd) begin
                    n_state = ST_C_SRD;
                end else if (r_i + 1'b1 < r_n) begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_C_RD;
                end else begin
                    n_state = ST_CLR;
                end
            end
            ST_C_SRD: begin
                n_state = ST_C_DIV;
            end
            ST_C_DIV: begin
                if (r_csum_rd != '0) begin
                    div_start = 1'b1;
                    n_state   = ST_C_DWT;
                end else if (r_i + 1'b1 < r_n) begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_C_RD;
                end else begin
                    n_state = ST_CLR;
                end
            end
            ST_C_DWT: begin
                basis_wd = div_quot;
                if (div_done) begin
                    basis_we = 1'b1;
                    if (r_i + 1'b1 < r_n) begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_C_RD;
                    end else begin
                        n_state = ST_CLR;
                    end
                end
            end
            ST_CLR: begin
                csum_we = 1'b1;
                csum_wa = FW'(r_clr);
                csum_wd = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_iter  = r_iter + 1'b1;
                    n_chk   = (r_chk == CHK_LAST) ? '0 : r_chk + 1'b1;
                    n_state = (r_done || n_iter >= r_max) ? ST_DONE : ST_ITER;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_cidx  <= idx;
                r_cslot <= CW'({1'b0, i_slot} + 4'd1);
                r_rd_ok <= idx_ok;
                r_n     <= n_clamped;
            end
            ST_A_ACC: begin
                r_acc <= ACC_W'(r_basis_rd);
                r_cnt <= r_lcnt_rd;
            end
            ST_A_LNK2: begin
                r_coef <= r_coef_rd;
            end
            ST_A_ADD: begin
                r_acc <= r_acc + ACC_W'(mul_rnd);
            end
            ST_B_MUL: begin
                r_val  <= r_basis_rd;
                r_upd  <= r_upd_rd;
                r_kind <= r_kind_rd;
                r_sup  <= r_sup_rd;
            end
            ST_C_CHK: begin
                r_val <= r_basis_rd;
                r_sup <= r_sup_rd;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_iter_cnt  <= '0;
            r_conv      <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_READ) begin
                r_out_valid <= 1'b1;
            end
            if (r_state == ST_DONE) begin
                r_out_valid <= 1'b1;
                r_iter_cnt  <= r_iter;
                r_conv      <= r_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_out_value <= r_rd_ok ? r_basis_rd : '0;
            r_out_iter  <= r_iter_cnt;
            r_out_conv  <= r_conv;
        end else if (r_state == ST_DONE) begin
            r_out_value <= '0;
            r_out_iter  <= r_iter;
            r_out_conv  <= r_done;
        end
    end

    assign o_in_ready        = ready;
    assign o_out_valid       = r_out_valid;
    assign o_read_value      = r_out_value;
    assign o_iterations_done = r_out_iter;
    assign o_converged       = r_out_conv;

endmodule

// File: sv/bsi_checker.sv
module bsi_checker
    import bsi_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_we,
    input logic [1:0]         i_cfg_index,
    input logic [30:0]        i_cfg_data,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic [1:0]         i_cmd,
    input logic [11:0]        i_entry_index,
    input logic [2:0]         i_slot,
    input logic [11:0]        i_link,
    input logic signed [31:0] i_data_value,
    input logic [1:0]         i_cell_kind,
    input logic [9:0]         i_fine_cell,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_read_value,
    input logic [15:0]        o_iterations_done,
    input logic               o_converged
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_cmd == CMD_RUN |=> !o_in_ready)
        else $error("ready straight after run transfer");

    a_conv_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_converged |-> o_iterations_done != 16'd0)
        else $error("converged with no iterations");

endmodule

bind basis_smoothing_iteration_unit bsi_checker u_bsi_checker (.*);
